### rtl/wsdm_pkg.sv
// Shared types and constants of the waveshaper distortion mix block.
package wsdm_pkg;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int CURVE_BITS = 17;

	localparam logic [15:0] DRIVE_RESET = 16'd4096;
	localparam logic [15:0] WET_RESET = 16'd16384;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SHAPE_MODE  = 3'd0,
		REG_DRIVE_GAIN  = 3'd1,
		REG_FOLD_DEPTH  = 3'd2,
		REG_BIAS_OFFSET = 3'd3,
		REG_WET_MIX     = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SHAPE_CLIP   = 2'd0,
		SHAPE_TANH   = 2'd1,
		SHAPE_FOLD   = 2'd2,
		SHAPE_BYPASS = 2'd3
	} shape_t;

endpackage

### rtl/wsdm_curve_rom.sv
// Constant curve table (tanh or one sine period) with two registered read ports.
module wsdm_curve_rom #(
	parameter int DEPTH = 256,
	parameter bit IS_TANH = 1'b0,
	localparam int ENTRIES = DEPTH + int'(IS_TANH),
	localparam int AW = $clog2(ENTRIES)
) (
	input  logic                                       clk,
	input  logic [AW-1:0]                              rd_a_addr,
	input  logic [AW-1:0]                              rd_b_addr,
	output logic signed [wsdm_pkg::CURVE_BITS-1:0]     rd_a_data,
	output logic signed [wsdm_pkg::CURVE_BITS-1:0]     rd_b_data
);

	localparam int CB = wsdm_pkg::CURVE_BITS;
	localparam longint unsigned Q30_ONE = 64'd1073741824;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint TWO_PI_Q30 = 64'sd6746518852;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	logic signed [CB-1:0] rom_tbl [ENTRIES];

	for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
		if (IS_TANH) begin : g_tanh
			localparam longint unsigned T0 = (64'(k) << 34) / DEPTH;
			localparam longint unsigned U = T0 >> 5;
			localparam longint unsigned TM1 = ((Q30_ONE * U) >> 30) / 1;
			localparam longint unsigned TM2 = ((TM1 * U) >> 30) / 2;
			localparam longint unsigned TM3 = ((TM2 * U) >> 30) / 3;
			localparam longint unsigned TM4 = ((TM3 * U) >> 30) / 4;
			localparam longint unsigned TM5 = ((TM4 * U) >> 30) / 5;
			localparam longint unsigned TM6 = ((TM5 * U) >> 30) / 6;
			localparam longint unsigned TM7 = ((TM6 * U) >> 30) / 7;
			localparam longint unsigned TM8 = ((TM7 * U) >> 30) / 8;
			localparam longint unsigned TM9 = ((TM8 * U) >> 30) / 9;
			localparam longint unsigned TM10 = ((TM9 * U) >> 30) / 10;
			localparam longint unsigned TM11 = ((TM10 * U) >> 30) / 11;
			localparam longint unsigned TM12 = ((TM11 * U) >> 30) / 12;
			localparam longint SUM = longint'(Q30_ONE) - longint'(TM1) + longint'(TM2)
				- longint'(TM3) + longint'(TM4) - longint'(TM5) + longint'(TM6)
				- longint'(TM7) + longint'(TM8) - longint'(TM9) + longint'(TM10)
				- longint'(TM11) + longint'(TM12);
			localparam longint unsigned E0 = SUM;
			localparam longint unsigned E1 = (E0 * E0 + (64'd1 << 29)) >> 30;
			localparam longint unsigned E2 = (E1 * E1 + (64'd1 << 29)) >> 30;
			localparam longint unsigned E3 = (E2 * E2 + (64'd1 << 29)) >> 30;
			localparam longint unsigned E4 = (E3 * E3 + (64'd1 << 29)) >> 30;
			localparam longint unsigned E5 = (E4 * E4 + (64'd1 << 29)) >> 30;
			localparam longint unsigned NUM = Q30_ONE - E5;
			localparam longint unsigned TDEN = Q30_ONE + E5;
			localparam longint unsigned VAL = (NUM * 64'd32768 + TDEN / 2) / TDEN;
			assign rom_tbl[k] = CB'(VAL);
		end else begin : g_sin
			localparam longint KS = (2 * k >= DEPTH) ? k - DEPTH : k;
			localparam longint X0 = KS * TWO_PI_Q30 / DEPTH;
			localparam longint X1 = (X0 > HALF_PI_Q30) ? PI_Q30 - X0 :
				((X0 < -HALF_PI_Q30) ? -PI_Q30 - X0 : X0);
			localparam bit NEG = X1 < 0;
			localparam longint unsigned UX = NEG ? -X1 : X1;
			localparam longint unsigned X2 = (UX * UX) >> 30;
			localparam longint unsigned SN1 = ((UX * X2) >> 30) / 6;
			localparam longint unsigned SN2 = ((SN1 * X2) >> 30) / 20;
			localparam longint unsigned SN3 = ((SN2 * X2) >> 30) / 42;
			localparam longint unsigned SN4 = ((SN3 * X2) >> 30) / 72;
			localparam longint unsigned SN5 = ((SN4 * X2) >> 30) / 110;
			localparam longint unsigned SN6 = ((SN5 * X2) >> 30) / 156;
			localparam longint unsigned SN7 = ((SN6 * X2) >> 30) / 210;
			localparam longint SUM = longint'(UX) - longint'(SN1) + longint'(SN2)
				- longint'(SN3) + longint'(SN4) - longint'(SN5) + longint'(SN6)
				- longint'(SN7);
			localparam longint V0 = (SUM < 0) ? 64'sd0 : ((SUM + 64'sd16384) >>> 15);
			localparam longint V1 = (V0 > 64'sd32768) ? 64'sd32768 : V0;
			localparam longint VAL = NEG ? -V1 : V1;
			assign rom_tbl[k] = CB'(VAL);
		end
	end

	always_ff @(posedge clk) begin
		rd_a_data <= rom_tbl[rd_a_addr];
		rd_b_data <= rom_tbl[rd_b_addr];
	end

endmodule

### rtl/waveshaper_distortion_mix.sv
// Top level of the waveshaper distortion mix pipeline.
//
//   channel   direction  handshake              payload
//   command   in         start, busy            sample_in, last_in
//   result    out        done (one-cycle beat)  sample_out, clipped, last_out
//   config    in         cfg_we                 cfg_index, cfg_wdata
//
// One beat enters per cycle; busy stays low. The pipeline depth is set by the tanh
// path (gain multiply, table address multiply, registered table read, interpolation)
// ahead of the mix multipliers. Reset clears the stage valid bits and loads the
// register defaults; the curve tables are constant and need no fill. The receiver
// cannot stall, so the pipeline advances every cycle.
module waveshaper_distortion_mix #(
	parameter int CURVE_TABLE_DEPTH = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic signed [SAMPLE_BITS-1:0]            sample_in,
	input  logic                                     last_in,
	output logic                                     done,
	output logic signed [SAMPLE_BITS-1:0]            sample_out,
	output logic                                     clipped,
	output logic                                     last_out,
	input  logic                                     cfg_we,
	input  logic [wsdm_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
	input  logic [wsdm_pkg::CFG_DATA_BITS-1:0]       cfg_wdata
);

	localparam int W = SAMPLE_BITS;
	localparam int F = W - 1;
	localparam int SW = W + 1;
	localparam int PW = W + 18;
	localparam int YW = W + 5;
	localparam int TFB = W + 2;
	localparam int SAW = $clog2(CURVE_TABLE_DEPTH);
	localparam int TAW = $clog2(CURVE_TABLE_DEPTH + 1);
	localparam int DEPW = $clog2(CURVE_TABLE_DEPTH + 1);
	localparam int CB = wsdm_pkg::CURVE_BITS;
	localparam int DFW = CB + 1;
	localparam int SLW = DFW + W + 1;
	localparam int TLW = DFW + TFB + 1;
	localparam int FVW = CB + 16;
	localparam int FSH = 29 - F;
	localparam int MW = YW + 18;
	localparam int MOW = MW - 15;
	localparam int LAT = 11;
	localparam logic [DEPW-1:0] DEP = DEPW'(CURVE_TABLE_DEPTH);
	localparam logic signed [YW-1:0] Y_ONE = YW'(1) << F;
	localparam logic signed [MOW-1:0] OUT_MAX = (MOW'(1) << F) - MOW'(1);
	localparam logic signed [MOW-1:0] OUT_MIN = ~OUT_MAX;

	typedef struct packed {
		logic                 last;
		logic signed [W-1:0]  x;
		logic signed [SW-1:0] s;
	} lane_t;

	typedef struct packed {
		logic                 dneg;
		logic                 big;
		logic signed [YW-1:0] yclip;
	} tbr_t;

	wsdm_pkg::shape_t shape_mode_q;
	logic [15:0]        drive_gain_q;
	logic signed [15:0] fold_depth_q;
	logic signed [15:0] bias_offset_q;
	logic [15:0]        wet_mix_q;

	logic [LAT-1:0] vld_q;

	lane_t lane_s1, lane_s2, lane_s3, lane_s4, lane_s5;
	lane_t lane_s6, lane_s7, lane_s8, lane_s9, lane_s10;
	tbr_t  br_s4, br_s5, br_s6, br_s7, br_s8;

	logic signed [SW-1:0]  bias_fx;
	logic signed [PW-1:0]  prod_s2;
	logic signed [PW-1:0]  prod_rnd;
	logic [W+DEPW-1:0]     psin_s3;
	logic signed [YW-1:0]  d_s3;
	logic [YW-1:0]         d_mag;
	logic [TFB-1:0]        mag_s4;
	logic [SAW-1:0]        sin_ia, sin_ib;
	logic signed [CB-1:0]  sin_a_s4, sin_b_s4;
	logic [W-1:0]          fs_s4;
	logic [TFB+DEPW-1:0]   ptanh_s5;
	logic signed [DFW-1:0] sin_diff;
	logic signed [SLW-1:0] sprod_s5;
	logic signed [CB-1:0]  sa_s5;
	logic [TAW-1:0]        tan_ia, tan_ib;
	logic signed [CB-1:0]  tan_a_s6, tan_b_s6;
	logic [TFB-1:0]        ft_s6;
	logic signed [SLW-1:0] sprod_rnd;
	logic signed [DFW:0]   sv_sum;
	logic signed [CB-1:0]  v_s6;
	logic signed [DFW-1:0] tan_diff;
	logic signed [TLW-1:0] tprod_s7;
	logic signed [CB-1:0]  ta_s7;
	logic signed [FVW-1:0] fv_s7;
	logic signed [TLW-1:0] tprod_rnd;
	logic signed [DFW:0]   tsum;
	logic [CB-1:0]         t_s8;
	logic signed [FVW-1:0] fv_rnd;
	logic signed [YW-1:0]  ysine_s8;
	logic [CB-1:0]         t_sel;
	logic [SW-1:0]         tmag;
	logic signed [YW-1:0]  ytanh;
	logic signed [YW-1:0]  y_sel;
	logic signed [YW-1:0]  y_s9;
	logic signed [16:0]    dry;
	logic signed [YW+16:0] py_s10;
	logic signed [W+16:0]  px_s10;
	logic signed [MW-1:0]  msum;
	logic signed [MOW-1:0] m_full;
	logic signed [W-1:0]   sample_out_s11;
	logic                  clipped_s11;
	logic                  last_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_mode_q  <= wsdm_pkg::SHAPE_CLIP;
			drive_gain_q  <= wsdm_pkg::DRIVE_RESET;
			fold_depth_q  <= '0;
			bias_offset_q <= '0;
			wet_mix_q     <= wsdm_pkg::WET_RESET;
		end else if (cfg_we) begin
			unique case (wsdm_pkg::cfg_reg_t'(cfg_index))
				wsdm_pkg::REG_SHAPE_MODE:  shape_mode_q  <= wsdm_pkg::shape_t'(cfg_wdata[1:0]);
				wsdm_pkg::REG_DRIVE_GAIN:  drive_gain_q  <= cfg_wdata;
				wsdm_pkg::REG_FOLD_DEPTH:  fold_depth_q  <= cfg_wdata;
				wsdm_pkg::REG_BIAS_OFFSET: bias_offset_q <= cfg_wdata;
				wsdm_pkg::REG_WET_MIX:     wet_mix_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end

	if (F >= 15) begin : g_bias_up
		assign bias_fx = SW'(bias_offset_q) <<< (F - 15);
	end else begin : g_bias_dn
		localparam int BSH = 15 - F;
		logic signed [16:0] bias_rs;
		assign bias_rs = 17'(bias_offset_q) + 17'(1 << (BSH - 1));
		assign bias_fx = SW'(bias_rs >>> BSH);
	end

	assign prod_rnd = prod_s2 + PW'(2048);
	assign d_mag = d_s3[YW-1] ? YW'(-d_s3) : YW'(d_s3);

	assign sin_ia = psin_s3[W+SAW-1:W];
	assign sin_ib = (sin_ia == SAW'(CURVE_TABLE_DEPTH - 1)) ? '0 : sin_ia + SAW'(1);

	wsdm_curve_rom #(
		.DEPTH   (CURVE_TABLE_DEPTH),
		.IS_TANH (1'b0)
	) u_sin_rom (
		.clk       (clk),
		.rd_a_addr (sin_ia),
		.rd_b_addr (sin_ib),
		.rd_a_data (sin_a_s4),
		.rd_b_data (sin_b_s4)
	);

	assign sin_diff = DFW'(sin_b_s4) - DFW'(sin_a_s4);

	assign tan_ia = ptanh_s5[TFB+TAW-1:TFB];
	assign tan_ib = tan_ia + TAW'(1);

	wsdm_curve_rom #(
		.DEPTH   (CURVE_TABLE_DEPTH),
		.IS_TANH (1'b1)
	) u_tanh_rom (
		.clk       (clk),
		.rd_a_addr (tan_ia),
		.rd_b_addr (tan_ib),
		.rd_a_data (tan_a_s6),
		.rd_b_data (tan_b_s6)
	);

	assign sprod_rnd = sprod_s5 + SLW'(1 << (W - 1));
	assign sv_sum = $signed(sprod_rnd[SLW-1:W]) + (DFW+1)'(sa_s5);

	assign tan_diff = DFW'(tan_b_s6) - DFW'(tan_a_s6);

	assign tprod_rnd = tprod_s7 + TLW'(1 << (TFB - 1));
	assign tsum = $signed(tprod_rnd[TLW-1:TFB]) + (DFW+1)'(ta_s7);
	assign fv_rnd = fv_s7 + FVW'(1 << (FSH - 1));

	assign t_sel = br_s8.big ? CB'(32768) : t_s8;

	if (F >= 15) begin : g_tanh_up
		assign tmag = SW'(t_sel) << (F - 15);
	end else begin : g_tanh_dn
		localparam int TSH = 15 - F;
		logic [CB-1:0] t_rs;
		assign t_rs = t_sel + CB'(1 << (TSH - 1));
		assign tmag = SW'(t_rs >> TSH);
	end

	assign ytanh = br_s8.dneg ? -YW'(tmag) : YW'(tmag);

	always_comb begin
		unique case (shape_mode_q)
			wsdm_pkg::SHAPE_CLIP:   y_sel = br_s8.yclip;
			wsdm_pkg::SHAPE_TANH:   y_sel = ytanh;
			wsdm_pkg::SHAPE_FOLD:   y_sel = ysine_s8;
			wsdm_pkg::SHAPE_BYPASS: y_sel = YW'(lane_s8.s);
			default:                y_sel = YW'(lane_s8.s);
		endcase
	end

	assign dry = 17'sd32768 - $signed({1'b0, wet_mix_q});
	assign msum = MW'(py_s10) + MW'(px_s10) + MW'(1 << 14);
	assign m_full = $signed(msum[MW-1:15]);

	always_ff @(posedge clk) begin
		lane_s1.last <= last_in;
		lane_s1.x    <= sample_in;
		lane_s1.s    <= SW'(sample_in) + bias_fx;

		lane_s2 <= lane_s1;
		prod_s2 <= PW'($signed({1'b0, drive_gain_q}) * lane_s1.s);

		lane_s3 <= lane_s2;
		d_s3    <= prod_rnd[W+16:12];
		psin_s3 <= (W+DEPW)'(lane_s2.s[W-1:0] * DEP);

		lane_s4       <= lane_s3;
		br_s4.dneg    <= d_s3[YW-1];
		br_s4.big     <= |d_mag[YW-1:TFB];
		br_s4.yclip   <= (d_s3 < Y_ONE) ? d_s3 : Y_ONE;
		mag_s4        <= d_mag[TFB-1:0];
		fs_s4         <= psin_s3[W-1:0];

		lane_s5  <= lane_s4;
		br_s5    <= br_s4;
		ptanh_s5 <= (TFB+DEPW)'(mag_s4 * DEP);
		sprod_s5 <= SLW'(sin_diff * $signed({1'b0, fs_s4}));
		sa_s5    <= sin_a_s4;

		lane_s6 <= lane_s5;
		br_s6   <= br_s5;
		ft_s6   <= ptanh_s5[TFB-1:0];
		v_s6    <= sv_sum[CB-1:0];

		lane_s7  <= lane_s6;
		br_s7    <= br_s6;
		tprod_s7 <= TLW'(tan_diff * $signed({1'b0, ft_s6}));
		ta_s7    <= tan_a_s6;
		fv_s7    <= FVW'(fold_depth_q * v_s6);

		lane_s8  <= lane_s7;
		br_s8    <= br_s7;
		t_s8     <= tsum[CB-1:0];
		ysine_s8 <= YW'(lane_s7.s) - YW'($signed(fv_rnd[FVW-1:FSH]));

		lane_s9 <= lane_s8;
		y_s9    <= y_sel;

		lane_s10 <= lane_s9;
		py_s10   <= (YW+17)'(y_s9 * $signed({1'b0, wet_mix_q}));
		px_s10   <= (W+17)'(lane_s9.x * dry);

		last_s11 <= lane_s10.last;
		if (m_full > OUT_MAX) begin
			sample_out_s11 <= OUT_MAX[W-1:0];
			clipped_s11    <= 1'b1;
		end else if (m_full < OUT_MIN) begin
			sample_out_s11 <= OUT_MIN[W-1:0];
			clipped_s11    <= 1'b1;
		end else begin
			sample_out_s11 <= m_full[W-1:0];
			clipped_s11    <= 1'b0;
		end
	end

	assign done       = vld_q[LAT-1];
	assign sample_out = sample_out_s11;
	assign clipped    = clipped_s11;
	assign last_out   = last_s11;

	a_beat_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result beat missing at pipeline exit");

	a_last_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (last_out == $past(last_in, LAT)))
		else $error("last marker out of step with its sample");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clipped) |->
		((sample_out == OUT_MAX[W-1:0]) || (sample_out == OUT_MIN[W-1:0])))
		else $error("saturation flag without a limit value");

endmodule
